// File: hdl/prle_pkg.sv
package prle_pkg;

  localparam int unsigned MAX_WIDTH        = 2048;
  localparam int unsigned WIDTH_W          = 12;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned PAL_DEPTH        = 256;
  localparam int unsigned PAL_IDX_W        = 8;
  localparam int unsigned FIFO_DEPTH       = 4;
  localparam int unsigned FIFO_PTR_W       = 2;
  localparam int unsigned FIFO_CNT_W       = 3;

  localparam logic [7:0]         RUN_MAX          = 8'd255;
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET = WIDTH_W'(640);
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0] LINE_WIDTH_MIN   = WIDTH_W'(1);

  // register index taken from paddr[2]
  localparam logic REG_LINE_WIDTH = 1'b0;

  // request kinds carried in tuser
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  typedef struct packed {
    logic       line_end;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] run_length;
  } rle_result_t;

  typedef struct packed {
    logic        push_a;
    logic        push_b;
    rle_result_t data_a;
    rle_result_t data_b;
  } rle_push_t;

endpackage

// File: hdl/prle_palette.sv
module prle_palette (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic                          rd_en_i,
  input  logic [prle_pkg::PAL_IDX_W-1:0] idx_i,
  input  prle_pkg::color_t              wr_color_i,
  output prle_pkg::color_t              rd_color_o
);

  prle_pkg::color_t mem [prle_pkg::PAL_DEPTH];
  prle_pkg::color_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[idx_i] <= wr_color_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[idx_i];
    end
  end

  assign rd_color_o = rd_q;

endmodule

// File: hdl/prle_run.sv
module prle_run (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pix_valid_i,
  input  prle_pkg::color_t              pix_color_i,
  input  logic [prle_pkg::WIDTH_W-1:0]  line_width_i,
  input  logic                          room_i,
  output logic                          stall_o,
  output prle_pkg::rle_push_t           push_o
);

  logic                         s1_valid_q, s1_valid_d;
  prle_pkg::color_t             run_color_q, run_color_d;
  logic [7:0]                   run_count_q, run_count_d;
  logic [prle_pkg::WIDTH_W-1:0] pixels_seen_q, pixels_seen_d;

  logic                         fire;
  logic                         open_run;
  logic                         brk;
  logic                         eol;
  logic [7:0]                   cnt1;
  prle_pkg::color_t             col1;
  logic [prle_pkg::WIDTH_W-1:0] seen1;
  logic [prle_pkg::WIDTH_W-1:0] eff_width;

  assign fire    = s1_valid_q && room_i;
  assign stall_o = s1_valid_q && !room_i;

  // clamp width into 1..MAX_WIDTH
  always_comb begin
    eff_width = line_width_i;
    if (line_width_i == '0) begin
      eff_width = prle_pkg::LINE_WIDTH_MIN;
    end else if (line_width_i > prle_pkg::LINE_WIDTH_MAX) begin
      eff_width = prle_pkg::LINE_WIDTH_MAX;
    end
  end

  assign open_run = (run_count_q != '0);
  assign brk      = open_run &&
                    ((pix_color_i != run_color_q) || (run_count_q >= prle_pkg::RUN_MAX));
  assign cnt1     = (brk || !open_run) ? 8'd1 : run_count_q + 8'd1;
  assign col1     = (brk || !open_run) ? pix_color_i : run_color_q;
  assign seen1    = pixels_seen_q + prle_pkg::WIDTH_W'(1);
  assign eol      = (seen1 >= eff_width);

  always_comb begin
    push_o.push_a            = fire && brk;
    push_o.data_a.line_end   = 1'b0;
    push_o.data_a.red        = run_color_q.red;
    push_o.data_a.green      = run_color_q.green;
    push_o.data_a.blue       = run_color_q.blue;
    push_o.data_a.run_length = run_count_q;
    push_o.push_b            = fire && eol;
    push_o.data_b.line_end   = 1'b1;
    push_o.data_b.red        = col1.red;
    push_o.data_b.green      = col1.green;
    push_o.data_b.blue       = col1.blue;
    push_o.data_b.run_length = cnt1;
  end

  always_comb begin
    s1_valid_d    = s1_valid_q;
    run_color_d   = run_color_q;
    run_count_d   = run_count_q;
    pixels_seen_d = pixels_seen_q;
    if (fire) begin
      s1_valid_d    = 1'b0;
      run_color_d   = col1;
      run_count_d   = eol ? 8'd0 : cnt1;
      pixels_seen_d = eol ? '0 : seen1;
    end
    if (pix_valid_i) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      run_color_q   <= '0;
      run_count_q   <= '0;
      pixels_seen_q <= '0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      run_color_q   <= run_color_d;
      run_count_q   <= run_count_d;
      pixels_seen_q <= pixels_seen_d;
    end
  end

  a_eol_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && eol |=> (pixels_seen_q == '0) && (run_count_q == '0))
    else $error("line end did not clear run state");

  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !eol |=> (run_count_q != '0) && (pixels_seen_q != '0))
    else $error("pixel left no open run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> s1_valid_q && $stable(run_count_q) && $stable(pixels_seen_q))
    else $error("run state moved while stalled");

  a_no_pix_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> !pix_valid_i)
    else $error("pixel request taken while run stage stalled");

endmodule

// File: hdl/prle_fifo.sv
module prle_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prle_pkg::rle_push_t    push_i,
  output logic                   room_o,
  output logic                   valid_o,
  input  logic                   ready_i,
  output prle_pkg::rle_result_t  data_o
);

  prle_pkg::rle_result_t           entry_q [prle_pkg::FIFO_DEPTH];
  logic [prle_pkg::FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [prle_pkg::FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [prle_pkg::FIFO_CNT_W-1:0] count_q, count_d;
  logic [prle_pkg::FIFO_PTR_W-1:0] wr_ptr_b;
  logic                            pop;

  assign pop      = valid_o && ready_i;
  assign valid_o  = (count_q != '0);
  assign data_o   = entry_q[rd_ptr_q];
  assign room_o   = (count_q <= prle_pkg::FIFO_CNT_W'(prle_pkg::FIFO_DEPTH - 2));
  assign wr_ptr_b = wr_ptr_q + prle_pkg::FIFO_PTR_W'(push_i.push_a);

  always_comb begin
    wr_ptr_d = wr_ptr_q + prle_pkg::FIFO_PTR_W'(push_i.push_a)
                        + prle_pkg::FIFO_PTR_W'(push_i.push_b);
    rd_ptr_d = rd_ptr_q + prle_pkg::FIFO_PTR_W'(pop);
    count_d  = count_q + prle_pkg::FIFO_CNT_W'(push_i.push_a)
                       + prle_pkg::FIFO_CNT_W'(push_i.push_b)
                       - prle_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      entry_q[wr_ptr_q] <= push_i.data_a;
    end
    if (push_i.push_b) begin
      entry_q[wr_ptr_b] <= push_i.data_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push_a || push_i.push_b) |-> room_o)
    else $error("result queue pushed without room");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= prle_pkg::FIFO_CNT_W'(prle_pkg::FIFO_DEPTH))
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[prle_pkg::FIFO_PTR_W-1:0])
    else $error("result queue pointers disagree with count");

endmodule

// File: hdl/palette_rle_line_encoder.sv
// path: a pixel request registers its palette read and its run state, its runs are then
//   written into the result queue and leave on m_axis; a second result of the same pixel follows it
// throughput: one request per cycle; the run stage holds while the 4-entry result queue
//   has fewer than two free slots, so each pixel can deposit up to two runs
// reset: asynchronous, active low; clears the run state, the queue and sets line_width to
//   640; the palette memory is not cleared and holds garbage until written
module palette_rle_line_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // pixel_index, red_in, green_in, blue_in
  input  logic [0:0]                      s_axis_tuser,  // action
  // run stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [31:0]                     m_axis_tdata,  // run_length, blue_out, green_out, red_out
  output logic                            m_axis_tlast,  // line_end
  // register port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [prle_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [prle_pkg::APB_DATA_W-1:0] pwdata,
  output logic [prle_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [prle_pkg::WIDTH_W-1:0] line_width_q;
  logic                         cfg_wr;

  logic                         in_accept;
  logic                         pal_wr;
  logic                         pix_rd;
  logic                         run_stall;
  logic                         q_room;
  prle_pkg::color_t             wr_color;
  prle_pkg::color_t             pix_color;
  prle_pkg::rle_push_t          push;
  prle_pkg::rle_result_t        head;

  // register port, single line_width register, no wait states
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == prle_pkg::REG_LINE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= prle_pkg::LINE_WIDTH_RESET;
    end else if (cfg_wr) begin
      line_width_q <= pwdata[prle_pkg::WIDTH_W-1:0];
    end
  end

  // reads outside the register return zero
  always_comb begin
    prdata = '0;
    if (paddr[2] == prle_pkg::REG_LINE_WIDTH) begin
      prdata = prle_pkg::APB_DATA_W'(line_width_q);
    end
  end

  // input side: tdata holds the index in the low byte, then red, green, blue
  assign s_axis_tready = !run_stall;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign pal_wr        = in_accept && (s_axis_tuser[0] == prle_pkg::ACT_PALETTE);
  assign pix_rd        = in_accept && (s_axis_tuser[0] == prle_pkg::ACT_PIXEL);

  assign wr_color.red   = s_axis_tdata[15:8];
  assign wr_color.green = s_axis_tdata[23:16];
  assign wr_color.blue  = s_axis_tdata[31:24];

  // palette read is registered at the accept edge; a write taken at an earlier
  // edge has already landed, so no bypass is needed
  prle_palette u_palette (
    .clk_i      (clk_i),
    .wr_en_i    (pal_wr),
    .rd_en_i    (pix_rd),
    .idx_i      (s_axis_tdata[prle_pkg::PAL_IDX_W-1:0]),
    .wr_color_i (wr_color),
    .rd_color_o (pix_color)
  );

  // run merge, line counting and closing of runs
  prle_run u_run (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (pix_rd),
    .pix_color_i  (pix_color),
    .line_width_i (line_width_q),
    .room_i       (q_room),
    .stall_o      (run_stall),
    .push_o       (push)
  );

  // result queue, takes up to two runs per cycle and hands out one while m_axis_tready is high
  prle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (q_room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (head)
  );

  assign m_axis_tdata = {head.red, head.green, head.blue, head.run_length};
  assign m_axis_tlast = head.line_end;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  // run ends if nothing moves on any port for this many cycles
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned MAX_REPORTS = 10;
  // cycles the result side stays blocked in the pressure test
  localparam int unsigned HOLD_OFF    = 300;
  // settle time after the last run, covers a pixel still in the pipe
  localparam int unsigned SETTLE      = 6;
  localparam logic [prle_pkg::APB_ADDR_W-1:0] LINE_WIDTH_ADDR =
    {prle_pkg::REG_LINE_WIDTH, 2'b00};

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [31:0]                     s_axis_tdata;
  logic [0:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [31:0]                     m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [prle_pkg::APB_ADDR_W-1:0] paddr;
  logic [prle_pkg::APB_DATA_W-1:0] pwdata;
  logic [prle_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  palette_rle_line_encoder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // pixel_index, red_in, green_in, blue_in
    .s_axis_tuser (s_axis_tuser),   // action
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // run_length, blue_out, green_out, red_out
    .m_axis_tlast (m_axis_tlast),   // line_end
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // mirror of the encoder state
  prle_pkg::color_t             pal_mem     [prle_pkg::PAL_DEPTH];
  bit                           pal_written [prle_pkg::PAL_DEPTH];
  prle_pkg::color_t             open_color;
  int unsigned                  open_count;
  int unsigned                  line_pos;
  logic [prle_pkg::WIDTH_W-1:0] width_reg;

  // runs still owed by the encoder, oldest first
  prle_pkg::rle_result_t pending_runs[$];

  int unsigned errors;
  int unsigned idle_cycles;
  int unsigned sender_burst;
  bit          sender_gaps_on;
  int unsigned hold_cycles;
  int unsigned random_items;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic prle_pkg::rle_result_t make_run(int unsigned count, prle_pkg::color_t c,
                                                     logic last);
    prle_pkg::rle_result_t r;
    r.run_length = count[7:0];
    r.red        = c.red;
    r.green      = c.green;
    r.blue       = c.blue;
    r.line_end   = last;
    return r;
  endfunction

  // updates the mirror for one accepted request and queues the runs it closes
  function automatic void predict_runs(logic action, logic [7:0] idx, prle_pkg::color_t c);
    prle_pkg::color_t pix;
    int unsigned      eff_width;
    if (action == prle_pkg::ACT_PALETTE) begin
      pal_mem[idx]     = c;
      pal_written[idx] = 1'b1;
      return;
    end
    pix = pal_mem[idx];
    // colour change or a full run closes the open run first
    if (open_count != 0 && (pix != open_color || open_count >= prle_pkg::RUN_MAX)) begin
      pending_runs.push_back(make_run(open_count, open_color, 1'b0));
      open_count = 0;
    end
    if (open_count == 0) begin
      open_color = pix;
      open_count = 1;
    end else begin
      open_count++;
    end
    line_pos++;
    // zero width acts as one, anything past the maximum saturates
    eff_width = 32'(width_reg);
    if (eff_width == 0) eff_width = 1;
    if (eff_width > prle_pkg::MAX_WIDTH) eff_width = prle_pkg::MAX_WIDTH;
    if (line_pos >= eff_width) begin
      pending_runs.push_back(make_run(open_count, open_color, 1'b1));
      open_count = 0;
      line_pos   = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk_i) begin
    prle_pkg::rle_result_t got;
    prle_pkg::rle_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tlast, m_axis_tdata};
      if (pending_runs.size() == 0) begin
        report_mismatch("unexpected run", '0, got[31:0]);
      end else begin
        want = pending_runs.pop_front();
        if (got.run_length != want.run_length)
          report_mismatch("run_length", 32'(want.run_length), 32'(got.run_length));
        if (got.blue != want.blue)
          report_mismatch("blue_out", 32'(want.blue), 32'(got.blue));
        if (got.green != want.green)
          report_mismatch("green_out", 32'(want.green), 32'(got.green));
        if (got.red != want.red)
          report_mismatch("red_out", 32'(want.red), 32'(got.red));
        if (got.line_end != want.line_end)
          report_mismatch("line_end", 32'(want.line_end), 32'(got.line_end));
      end
    end
  end

  // watchdog: any accepted request or result, or register access, counts as progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode          = 0;
    mode_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles != 0) begin
        m_axis_tready = 1'b0;
        hold_cycles--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       m_axis_tready = 1'b1;                     // no stalls
          1:       m_axis_tready = 1'($urandom_range(0, 1)); // heavy stalls
          default: m_axis_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request; bursts of random length, with random gaps in between when gaps are on
  task automatic send_request(logic action, logic [7:0] idx, prle_pkg::color_t c);
    int unsigned gap;
    if (sender_burst == 0) begin
      sender_burst = $urandom_range(1, 24);
      gap          = sender_gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    sender_burst--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = action;
    s_axis_tdata  = {c.blue, c.green, c.red, idx};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_runs(action, idx, c);
  endtask

  // colour bits of a pixel request are don't care, so they toggle at random
  task automatic send_pixel(logic [7:0] idx);
    send_request(prle_pkg::ACT_PIXEL, idx, prle_pkg::color_t'(24'($urandom)));
  endtask

  function automatic logic [7:0] pick_written();
    logic [7:0] idx;
    do idx = 8'($urandom_range(0, prle_pkg::PAL_DEPTH - 1)); while (!pal_written[idx]);
    return idx;
  endfunction

  // lets the encoder run dry before the register may change
  task automatic finish_outstanding();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic config_line_width(int unsigned value);
    finish_outstanding();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LINE_WIDTH_ADDR;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    width_reg = value[prle_pkg::WIDTH_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // line_width reads back its reset value
  task automatic test_register_reset();
    @(negedge clk_i);
    psel   = 1'b1;
    pwrite = 1'b0;
    paddr  = LINE_WIDTH_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[prle_pkg::WIDTH_W-1:0] != prle_pkg::LINE_WIDTH_RESET)
      report_mismatch("line_width after reset", 32'(prle_pkg::LINE_WIDTH_RESET),
                      32'(prdata[prle_pkg::WIDTH_W-1:0]));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // field extremes, merging across indexes, width corner cases
  task automatic test_directed();
    sender_gaps_on = 1'b1;
    config_line_width(4);
    send_request(prle_pkg::ACT_PALETTE, 8'h00, prle_pkg::color_t'(24'h000000));
    send_request(prle_pkg::ACT_PALETTE, 8'hFF, prle_pkg::color_t'(24'hFFFFFF));
    send_request(prle_pkg::ACT_PALETTE, 8'h55, prle_pkg::color_t'(24'hAA55AA));
    send_request(prle_pkg::ACT_PALETTE, 8'hAA, prle_pkg::color_t'(24'h55AA55));
    // second index holding black, merges with entry zero
    send_request(prle_pkg::ACT_PALETTE, 8'h01, prle_pkg::color_t'(24'h000000));
    send_pixel(8'h00);
    send_pixel(8'h01);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    // zero width behaves as one pixel per line
    config_line_width(0);
    send_pixel(8'hAA);
    send_pixel(8'h00);
    // oversized width saturates, run stays open
    config_line_width(12'hFFF);
    send_pixel(8'h55);
    send_pixel(8'h55);
    // narrower than pixels seen: next pixel closes the run and the line
    config_line_width(2);
    send_pixel(8'hFF);
    // palette rewrite mid-line, open run keeps its latched colour
    config_line_width(8);
    send_pixel(8'h55);
    send_pixel(8'h55);
    send_request(prle_pkg::ACT_PALETTE, 8'h55, prle_pkg::color_t'(24'h123456));
    send_pixel(8'h55);
    repeat (5) send_pixel(8'hAA);
  endtask

  // one colour longer than a run can hold
  task automatic test_full_run();
    sender_gaps_on = 1'b0;
    config_line_width(300);
    send_request(prle_pkg::ACT_PALETTE, 8'h3C, prle_pkg::color_t'(24'($urandom)));
    repeat (300) send_pixel(8'h3C);
  endtask

  // phases of random width, mostly runs of written colours with some noise
  task automatic test_random();
    int unsigned phase_len;
    int unsigned n;
    int unsigned run_len;
    int unsigned pick;
    logic [7:0]  idx;
    while (random_items < 340) begin
      case ($urandom_range(0, 9))
        0:       config_line_width(0);
        1:       config_line_width(1);
        2:       config_line_width(2);
        3:       config_line_width(prle_pkg::MAX_WIDTH);
        4:       config_line_width(12'hFFF);
        5:       config_line_width($urandom_range(3, 8));
        6:       config_line_width($urandom_range(9, 40));
        7:       config_line_width($urandom_range(41, 300));
        default: config_line_width($urandom_range(1, 4095));
      endcase
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      phase_len      = $urandom_range(30, 90);
      n              = 0;
      while (n < phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          // noise: any entry, any colour
          send_request(prle_pkg::ACT_PALETTE, 8'($urandom_range(0, 255)),
                       prle_pkg::color_t'(24'($urandom)));
          n++;
        end else if (pick < 20) begin
          // few distinct colours so different indexes merge
          send_request(prle_pkg::ACT_PALETTE, 8'($urandom_range(0, 255)),
                       prle_pkg::color_t'(24'($urandom_range(0, 3) * 24'h404040)));
          n++;
        end else begin
          idx  = pick_written();
          pick = $urandom_range(0, 99);
          if (pick < 80) run_len = $urandom_range(1, 6);
          else if (pick < 97) run_len = $urandom_range(7, 40);
          else run_len = $urandom_range(200, 300);
          repeat (run_len) send_pixel(idx);
          n += run_len;
        end
      end
      random_items += n;
    end
  endtask

  // result side blocked long enough for the result queue to fill
  task automatic test_backpressure();
    sender_gaps_on = 1'b0;
    config_line_width(1);
    hold_cycles = HOLD_OFF;
    repeat (60) send_pixel(pick_written());
    sender_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    errors         = 0;
    sender_burst   = 0;
    sender_gaps_on = 1'b1;
    hold_cycles    = 0;
    random_items   = 0;
    open_color     = '0;
    open_count     = 0;
    line_pos       = 0;
    width_reg      = prle_pkg::LINE_WIDTH_RESET;
    for (int i = 0; i < prle_pkg::PAL_DEPTH; i++) begin
      pal_mem[i]     = '0;
      pal_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_reset();
    test_directed();
    test_full_run();
    test_backpressure();
    test_random();

    finish_outstanding();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/prle_pkg.sv
hdl/prle_palette.sv
hdl/prle_run.sv
hdl/prle_fifo.sv
hdl/palette_rle_line_encoder.sv
tb/tb.sv
